// ----- src/thread_ready_queue_scheduler_core_assert.svh -----
// Assertion macros for the ready-queue scheduler
`ifndef THREAD_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define THREAD_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TRQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/trqs_pkg.sv -----
// Shared types and constants for the ready-queue scheduler
package trqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_SWITCH  = 3'd2;
    localparam logic [2:0] ST_KEEP    = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    localparam logic [1:0] MODE_RR    = 2'd0;
    localparam logic [1:0] MODE_LOT   = 2'd1;
    localparam logic [1:0] MODE_PRIO  = 2'd2;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic scan_start;  // reset scan index and accumulators
        logic scan_step;   // consume one read word
        logic mod_start;   // start remainder
        logic mod_step;    // one remainder bit
        logic pick_start;  // start second lottery pass
        logic shift_start; // begin compaction at chosen position
        logic shift_step;  // move one entry down
        logic push_new;    // append input item
        logic push_run;    // append running thread
        logic commit;      // update running regs and count
        logic res_load;    // load output register
        logic [2:0] res_status;
        logic drop_run;    // clear running_valid
    } trqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic kind;
        logic empty;
        logic full;
        logic run_keep;    // running_valid && still
        logic [1:0] mode;
        logic scan_last;   // current index is last entry
        logic sum_zero;
        logic mod_done;
        logic hit;         // lottery acc exceeds winner
        logic shift_last;  // compaction reached tail
    } trqs_sts_t;

endpackage

// ----- src/trqs_ram.sv -----
// Generic single-write, single-read RAM with registered read
module trqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/trqs_datapath.sv -----
// Queue storage, scan, remainder and result registers
module trqs_datapath #(
    parameter int QUEUE_DEPTH = trqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trqs_pkg::trqs_cmd_t   cmd,
    output trqs_pkg::trqs_sts_t   sts,
    input  logic [1:0]            sched_mode,
    input  logic                  kind,
    input  logic [5:0]            thread_id,
    input  logic [7:0]            ticket_count,
    input  logic [7:0]            priority_level,
    input  logic                  current_still_running,
    input  logic [15:0]           random_value,
    output logic [2:0]            status,
    output logic [5:0]            selected_id,
    output logic [4:0]            queue_count
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = 8 + CW;

    logic          kind_reg;
    logic [5:0]    tid_reg;
    logic [7:0]    tk_reg, pr_reg;
    logic          still_reg;
    logic [15:0]   rnd_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          run_valid_reg;
    logic [5:0]    run_id_reg;
    logic [7:0]    run_tk_reg, run_pr_reg;

    logic [AW-1:0] idx_reg;     // scan / shift position
    logic [SW-1:0] acc_reg;     // ticket sum or running sum
    logic [SW-1:0] rem_reg;     // remainder (winning number)
    logic [4:0]    mbit_reg;    // remainder bit counter
    logic [7:0]    best_pr_reg;
    logic [AW-1:0] pos_reg;
    logic [5:0]    pick_id_reg;
    logic [7:0]    pick_tk_reg, pick_pr_reg;
    logic          lot_pass_reg;

    logic [2:0]    status_reg;
    logic [5:0]    sel_reg;
    logic [4:0]    qc_reg;

    logic [5:0]    rd_id;
    logic [7:0]    rd_tk, rd_pr;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [5:0]    wd_id;
    logic [7:0]    wd_tk, wd_pr;

    // read address leads idx by one at shift start and by two during shift steps; pos when no scan is running
    always_comb
    begin
        raddr = pos_reg;
        if (cmd.shift_start)
        begin
            raddr = AW'(pos_reg + 1'b1);
        end
        else if (cmd.shift_step)
        begin
            raddr = AW'(idx_reg + 2'd2);
        end
        else if (cmd.scan_start || cmd.pick_start)
        begin
            raddr = '0;
        end
        else if (cmd.scan_step)
        begin
            raddr = AW'(idx_reg + 1'b1);
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wd_id = rd_id;
        wd_tk = rd_tk;
        wd_pr = rd_pr;
        if (cmd.shift_step)
        begin
            we = 1'b1;
        end
        else if (cmd.push_new)
        begin
            we    = 1'b1;
            waddr = AW'(count_reg);
            wd_id = tid_reg;
            wd_tk = tk_reg;
            wd_pr = pr_reg;
        end
        else if (cmd.push_run)
        begin
            // picked entry is already removed: new tail is old count minus one
            we    = 1'b1;
            waddr = AW'(count_reg - 1'b1);
            wd_id = run_id_reg;
            wd_tk = run_tk_reg;
            wd_pr = run_pr_reg;
        end
    end

    trqs_ram #(.WIDTH(6), .DEPTH(QUEUE_DEPTH)) u_ids (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_id), .raddr(raddr), .rdata(rd_id));
    trqs_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_tks (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_tk), .raddr(raddr), .rdata(rd_tk));
    trqs_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_prs (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_pr), .raddr(raddr), .rdata(rd_pr));

    logic [SW-1:0] acc_sum;
    logic [SW:0]   rem_sh;
    assign acc_sum = acc_reg + SW'(rd_tk);
    assign rem_sh  = {rem_reg, rnd_reg[15 - mbit_reg[3:0]]};

    assign sts.kind       = kind_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg >= CW'(QUEUE_DEPTH));
    assign sts.run_keep   = run_valid_reg && still_reg;
    assign sts.mode       = sched_mode;
    assign sts.scan_last  = (CW'(idx_reg) + 1'b1 >= count_reg);
    assign sts.sum_zero   = (acc_reg == '0);
    assign sts.mod_done   = (mbit_reg == 5'd16);
    assign sts.hit        = (acc_sum > rem_reg);
    assign sts.shift_last = (CW'(idx_reg) + 1'b1 >= count_reg);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_new)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.commit)
        begin
            count_next = sts.run_keep ? count_reg : CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_tk_reg    <= '0;
            run_pr_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.drop_run)
            begin
                run_valid_reg <= 1'b0;
            end
            else if (cmd.commit)
            begin
                run_valid_reg <= 1'b1;
                run_id_reg    <= pick_id_reg;
                run_tk_reg    <= pick_tk_reg;
                run_pr_reg    <= pick_pr_reg;
            end
        end
    end

    // count at output: commit lowers by one unless running thread returns
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            tid_reg   <= thread_id;
            tk_reg    <= ticket_count;
            pr_reg    <= priority_level;
            still_reg <= current_still_running;
            rnd_reg   <= random_value;
        end
        if (cmd.scan_start || cmd.pick_start)
        begin
            idx_reg      <= '0;
            acc_reg      <= '0;
            pos_reg      <= '0;
            best_pr_reg  <= '1;
            lot_pass_reg <= cmd.pick_start;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= AW'(idx_reg + 1'b1);
            acc_reg <= acc_sum;
            if (!lot_pass_reg && (idx_reg == '0 || rd_pr < best_pr_reg))
            begin
                best_pr_reg <= rd_pr;
                pos_reg     <= idx_reg;
            end
            if (lot_pass_reg)
            begin
                pos_reg <= idx_reg;
            end
        end
        else if (cmd.shift_start)
        begin
            idx_reg <= pos_reg;
        end
        else if (cmd.shift_step)
        begin
            idx_reg <= AW'(idx_reg + 1'b1);
        end
        if (cmd.mod_start)
        begin
            rem_reg  <= '0;
            mbit_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            mbit_reg <= mbit_reg + 1'b1;
            if (rem_sh >= {1'b0, acc_reg})
            begin
                rem_reg <= SW'(rem_sh - {1'b0, acc_reg});
            end
            else
            begin
                rem_reg <= SW'(rem_sh);
            end
        end
        // entry at pos is captured when shift starts (read issued earlier at pos)
        if (cmd.shift_start)
        begin
            pick_id_reg <= rd_id;
            pick_tk_reg <= rd_tk;
            pick_pr_reg <= rd_pr;
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            sel_reg    <= '0;
            qc_reg     <= 5'(count_next);
            if (cmd.res_status == trqs_pkg::ST_SWITCH)
            begin
                sel_reg <= pick_id_reg;
            end
            else if (cmd.res_status == trqs_pkg::ST_KEEP)
            begin
                sel_reg <= run_id_reg;
            end
        end
    end

    assign status      = status_reg;
    assign selected_id = sel_reg;
    assign queue_count = qc_reg;
endmodule

// ----- src/trqs_ctrl.sv -----
// Sequencer for add and schedule items
module trqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output trqs_pkg::trqs_cmd_t cmd,
    input  trqs_pkg::trqs_sts_t sts
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_SUM    = 11'b00000000100,
        S_MOD    = 11'b00000001000,
        S_LOT    = 11'b00000010000,
        S_PRIO   = 11'b00000100000,
        S_RDPOS  = 11'b00001000000,
        S_GRAB   = 11'b00010000000,
        S_SHIFT  = 11'b00100000000,
        S_PUSH   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   scan_first_reg, scan_first_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // memory reads are registered: first cycle of a scan only primes the read
    always_comb
    begin
        state_next      = state_reg;
        scan_first_next = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.kind == trqs_pkg::KIND_ADD)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.full)
                    begin
                        cmd.res_status = trqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.push_new   = 1'b1;
                        cmd.res_status = trqs_pkg::ST_ADDED;
                    end
                    state_next = S_OUT;
                end
                else if (sts.empty)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.run_keep)
                    begin
                        cmd.res_status = trqs_pkg::ST_KEEP;
                    end
                    else
                    begin
                        cmd.res_status = trqs_pkg::ST_NONE;
                        cmd.drop_run   = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (sts.mode == trqs_pkg::MODE_LOT)
                begin
                    cmd.scan_start  = 1'b1;
                    scan_first_next = 1'b1;
                    state_next      = S_SUM;
                end
                else if (sts.mode == trqs_pkg::MODE_PRIO)
                begin
                    cmd.scan_start  = 1'b1;
                    scan_first_next = 1'b1;
                    state_next      = S_PRIO;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_RDPOS;
                end
            end
            S_SUM:
            begin
                if (scan_first_reg)
                begin
                    scan_first_next = 1'b0;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (sts.sum_zero)
                begin
                    // all tickets zero: take head
                    cmd.scan_start = 1'b1;
                    state_next     = S_RDPOS;
                end
                else if (sts.mod_done)
                begin
                    cmd.pick_start  = 1'b1;
                    scan_first_next = 1'b1;
                    state_next      = S_LOT;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_LOT:
            begin
                if (!scan_first_reg)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.hit || sts.scan_last)
                    begin
                        state_next = S_RDPOS;
                    end
                end
            end
            S_PRIO:
            begin
                if (!scan_first_reg)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_RDPOS;
                    end
                end
            end
            S_RDPOS:
            begin
                // no command: the read address defaults to pos_reg
                state_next = S_GRAB;
            end
            S_GRAB:
            begin
                cmd.shift_start = 1'b1;
                state_next      = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sts.shift_last)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_PUSH:
            begin
                // count still holds old value; write tail at count-1
                cmd.commit     = 1'b1;
                cmd.push_run   = sts.run_keep;
                cmd.res_load   = 1'b1;
                cmd.res_status = trqs_pkg::ST_SWITCH;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_first_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_first_reg <= scan_first_next;
        end
    end

    `include "thread_ready_queue_scheduler_core_assert.svh"

    `TRQS_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != S_IDLE, in_stall, "busy without stall")
    `TRQS_ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_reg == S_DECODE, "load lost")
    `TRQS_ASSERT_IMP(a_one_push, clk, rst_n, 1'b1, !(cmd.push_new && cmd.push_run), "two pushes")
    `TRQS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
endmodule

// ----- src/thread_ready_queue_scheduler_core.sv -----
// Top level: ready-queue thread scheduler
// An add or an empty-queue schedule goes from decode straight to the result; with
// entries queued a schedule runs entry-per-cycle scans (priority, lottery) and moves in
// the queue RAM, plus a 16-step remainder for lottery.
// One item at a time; the next is taken after the result transfers.
// Reset clears the queue count, running thread and mode; queue RAM is not cleared.
module thread_ready_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = trqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [5:0] thread_id,
    input  logic [7:0] ticket_count,
    input  logic [7:0] priority_level,
    input  logic       current_still_running,
    input  logic [15:0] random_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [5:0] selected_id,
    output logic [4:0] queue_count
);
    logic [1:0] mode_reg;
    trqs_pkg::trqs_cmd_t cmd;
    trqs_pkg::trqs_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= trqs_pkg::MODE_RR;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    trqs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));

    trqs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .sched_mode(mode_reg),
        .kind(kind), .thread_id(thread_id), .ticket_count(ticket_count),
        .priority_level(priority_level), .current_still_running(current_still_running),
        .random_value(random_value), .status(status), .selected_id(selected_id),
        .queue_count(queue_count));
endmodule
